[hw/rtl/ptc_pkg.sv]
// Package for the pressure and temperature compensation block.
// Holds the widths, formula constants, coefficient and queue entry types.
// No dependencies.
package ptc_pkg;

    // Field widths of the channels and the configuration port.
    localparam int RAW_W     = 20;
    localparam int TEMP_W    = 18;
    localparam int FINE_W    = 24;
    localparam int PRESS_W   = 20;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;

    // Widths of the divisor and the dividend handed from front to back.
    localparam int DIV_W = 40;
    localparam int NUM_W = 78;

    // Default number of items in flight between front and back.
    localparam int QUEUE_DEPTH_DEF = 4;

    // Formula constants.
    localparam int TEMP_OFFSET = 128000;
    localparam int PRESS_BASE  = 1048576;
    localparam int SCALE       = 3125;
    localparam int ROUND_BIAS  = 128;
    localparam logic [PRESS_W-1:0] PRESS_MAX = 20'hFFFFF;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMP_COEFFS = 2'd0,
        REG_PRESS_LOW   = 2'd1,
        REG_PRESS_HIGH  = 2'd2,
        REG_PRESS_NINE  = 2'd3
    } cfg_reg_t;

    // Decoded calibration coefficients.
    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } coef_t;

    // One queue entry: temperature results plus the division operands.
    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic        [FINE_W-1:0] fine;
        logic signed [DIV_W-1:0]  div;
        logic signed [NUM_W-1:0]  num;
    } entry_t;

endpackage

[hw/rtl/ptc_front.sv]
// Front part: accepts raw conversion pairs and runs the temperature path and
// the pressure pre-terms through a nine-stage pipeline. Uses ptc_pkg.
// Feeds ptc_queue; limits items in flight to the queue depth.
module ptc_front import ptc_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [RAW_W-1:0]   raw_temp,
    input  logic [RAW_W-1:0]   raw_press,
    input  coef_t              coef,
    output logic               q_push,
    output entry_t             q_data,
    input  logic               q_pop
);

    localparam int PEND_W = $clog2(DEPTH + 1);
    localparam int STAGES = 9;
    localparam int TD     = 6;
    localparam int RD     = 7;

    logic              accept;
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic [STAGES-1:0] vld_reg, vld_next;

    // Credit count: items accepted and not yet taken from the queue.
    assign accept    = in_valid && !in_stall;
    assign in_stall  = (pend_reg >= PEND_W'(DEPTH));
    assign pend_next = pend_reg + PEND_W'(accept) - PEND_W'(q_pop);
    assign vld_next  = {vld_reg[STAGES-2:0], accept};
    assign q_push    = vld_reg[STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            vld_reg  <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            vld_reg  <= vld_next;
        end
    end

    // Stage 1: offset terms and the first products.
    logic signed [19:0] x1, dt;
    logic signed [35:0] m1_reg, m1_next;
    logic signed [39:0] dsq_reg, dsq_next;

    assign x1 = $signed({3'b000, raw_temp[19:3]}) - $signed({3'b000, coef.t1, 1'b0});
    assign dt = $signed({4'b0000, raw_temp[19:4]}) - $signed({4'b0000, coef.t1});
    assign m1_next  = 36'(x1) * 36'(coef.t2);
    assign dsq_next = 40'(dt) * 40'(dt);

    // Stage 2: first term scaled, second-order term multiplied by T3.
    logic signed [39:0] dsh;
    logic signed [24:0] a1_reg, a1_next;
    logic signed [43:0] m3_reg, m3_next;

    assign dsh     = dsq_reg >>> 12;
    assign a1_next = 25'(m1_reg >>> 11);
    assign m3_next = 44'(dsh) * 44'(coef.t3);

    // Stage 3: fine temperature.
    logic signed [43:0] m3sh;
    logic signed [24:0] tf_reg, tf_next;

    assign m3sh    = m3_reg >>> 14;
    assign tf_next = a1_reg + 25'(m3sh);

    // Stage 4: temperature in hundredths and the pressure offset term.
    logic signed [28:0] tf5;
    logic signed [25:0] d_reg, d_next;
    logic [TEMP_W+FINE_W-1:0] tinfo_next;

    assign tf5        = 29'(tf_reg) * 29'sd5 + 29'(ROUND_BIAS);
    assign d_next     = 26'(tf_reg) - 26'(TEMP_OFFSET);
    assign tinfo_next = {tf5[25:8], tf_reg[FINE_W-1:0]};

    // Stage 5: products of the offset term.
    logic signed [51:0] dd_reg, dd_next;
    logic signed [41:0] dp5_reg, dp5_next, dp2_reg, dp2_next;

    assign dd_next  = 52'(d_reg) * 52'(d_reg);
    assign dp5_next = 42'(d_reg) * 42'(coef.p5);
    assign dp2_next = 42'(d_reg) * 42'(coef.p2);

    // Stage 6: squared term times P6 and P3.
    logic signed [67:0] v2a_reg, v2a_next, v1a_reg, v1a_next;
    logic signed [41:0] dp5b_reg, dp2b_reg;

    assign v2a_next = 68'(dd_reg) * 68'(coef.p6);
    assign v1a_next = 68'(dd_reg) * 68'(coef.p3);

    // Stage 7: the two variable sums.
    logic signed [67:0] v2_reg, v2_next;
    logic signed [59:0] v1_reg, v1_next;

    assign v2_next = v2a_reg + (68'(dp5b_reg) <<< 17) + (68'(coef.p4) <<< 35);
    assign v1_next = 60'(v1a_reg >>> 8) + (60'(dp2b_reg) <<< 12);

    // Stage 8: divisor product and the numerator before scaling.
    logic signed [60:0] base;
    logic        [20:0] rpd;
    logic signed [77:0] dmul_reg, dmul_next;
    logic signed [68:0] n0_reg, n0_next;
    logic [RAW_W-1:0]   rp_reg [RD];

    assign base      = (61'sd1 <<< 47) + 61'(v1_reg);
    assign dmul_next = 78'(base) * 78'($signed({1'b0, coef.p1}));
    assign rpd       = 21'(PRESS_BASE) - {1'b0, rp_reg[RD-1]};
    assign n0_next   = $signed(69'({rpd, 31'b0})) - 69'(v2_reg);

    // Stage 9: final divisor and scaled numerator, written to the queue.
    logic signed [77:0] dmsh;
    logic signed [81:0] num_full;
    logic signed [DIV_W-1:0] div_reg;
    logic signed [NUM_W-1:0] num_reg;
    logic [TEMP_W+FINE_W-1:0] tinfo_reg [TD];

    assign dmsh     = dmul_reg >>> 33;
    assign num_full = 82'(n0_reg) * 82'(SCALE);

    always_ff @(posedge clk)
    begin
        m1_reg   <= m1_next;
        dsq_reg  <= dsq_next;
        a1_reg   <= a1_next;
        m3_reg   <= m3_next;
        tf_reg   <= tf_next;
        d_reg    <= d_next;
        dd_reg   <= dd_next;
        dp5_reg  <= dp5_next;
        dp2_reg  <= dp2_next;
        v2a_reg  <= v2a_next;
        v1a_reg  <= v1a_next;
        dp5b_reg <= dp5_reg;
        dp2b_reg <= dp2_reg;
        v2_reg   <= v2_next;
        v1_reg   <= v1_next;
        dmul_reg <= dmul_next;
        n0_reg   <= n0_next;
        div_reg  <= $signed(dmsh[DIV_W-1:0]);
        num_reg  <= $signed(num_full[NUM_W-1:0]);
        rp_reg[0]    <= raw_press;
        tinfo_reg[0] <= tinfo_next;
        for (int i = 1; i < RD; i++)
        begin
            rp_reg[i] <= rp_reg[i-1];
        end
        for (int i = 1; i < TD; i++)
        begin
            tinfo_reg[i] <= tinfo_reg[i-1];
        end
    end

    // Queue entry from the last stage.
    always_comb
    begin
        q_data.temp = $signed(tinfo_reg[TD-1][TEMP_W+FINE_W-1:FINE_W]);
        q_data.fine = tinfo_reg[TD-1][FINE_W-1:0];
        q_data.div  = div_reg;
        q_data.num  = num_reg;
    end

endmodule

[hw/rtl/ptc_queue.sv]
// Short queue between front and back of the compensation block.
// Holds entry_t items from ptc_pkg; push and pop in the same cycle allowed.
module ptc_queue import ptc_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_data,
    input  logic   pop,
    output logic   empty,
    output entry_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t            mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign empty    = (cnt_reg == '0);
    assign do_push  = push && (cnt_reg < CNT_W'(DEPTH));
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    // Pointer wrap works for any depth.
    assign wr_ptr_next = !do_push ? wr_ptr_reg :
                         (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
    assign rd_ptr_next = !do_pop ? rd_ptr_reg :
                         (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
    assign cnt_next    = cnt_reg + CNT_W'(do_push) - CNT_W'(do_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hw/rtl/ptc_back.sv]
// Back part: signed division one quotient bit per cycle, then the
// second-order pressure terms on a shared shift-add multiplier, saturation
// and the output register. Uses ptc_pkg; reads entries from ptc_queue.
module ptc_back import ptc_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  coef_t                     coef,
    input  logic                      q_empty,
    input  entry_t                    q_data,
    output logic                      q_pop,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [TEMP_W-1:0]  temperature,
    output logic signed [FINE_W-1:0]  fine_temp,
    output logic        [PRESS_W-1:0] pressure,
    output logic                      divide_by_zero
);

    localparam int QS_SH = 13;
    localparam int QS_W  = NUM_W - QS_SH;
    localparam int MB_W  = QS_W;
    localparam int MA_W  = 2 * QS_W + 16;
    localparam int SUM_W = 124;
    localparam int CNT_W = $clog2(NUM_W);

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV, ST_QS, ST_SQ, ST_P9, ST_P8, ST_SUM, ST_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic signed [TEMP_W-1:0] temp_reg, temp_next;
    logic [FINE_W-1:0]       fine_reg, fine_next;
    logic                    dz_reg, dz_next;
    logic [DIV_W-1:0]        den_reg, den_next, rem_reg, rem_next;
    logic [NUM_W-1:0]        quo_reg, quo_next;
    logic                    qneg_reg, qneg_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [NUM_W-1:0] q_reg, q_next;
    logic [MA_W-1:0]         ma_reg, ma_next, acc_reg, acc_next;
    logic [MB_W-1:0]         mb_reg, mb_next;
    logic signed [SUM_W-1:0] ta_reg, ta_next, tb_reg, tb_next, s1_reg, s1_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [TEMP_W-1:0] out_temp_reg, out_temp_next;
    logic [FINE_W-1:0]       out_fine_reg, out_fine_next;
    logic [PRESS_W-1:0]      out_press_reg, out_press_next;
    logic                    out_dz_reg, out_dz_next;

    // Operand magnitudes of a new entry.
    logic [NUM_W-1:0] num_mag;
    logic [DIV_W-1:0] div_mag;
    assign num_mag = q_data.num[NUM_W-1] ? $unsigned(-q_data.num) : $unsigned(q_data.num);
    assign div_mag = q_data.div[DIV_W-1] ? $unsigned(-q_data.div) : $unsigned(q_data.div);

    // Restoring division step.
    logic [DIV_W:0] r2, r2_sub;
    logic           r2_ge;
    assign r2     = {rem_reg, quo_reg[NUM_W-1]};
    assign r2_ge  = (r2 >= {1'b0, den_reg});
    assign r2_sub = r2 - {1'b0, den_reg};

    // Signed quotient and the magnitude of its floor-shifted copy.
    logic signed [NUM_W-1:0] q_signed;
    logic [NUM_W-1:0]        qs_mag_full;
    assign q_signed    = qneg_reg ? -$signed(quo_reg) : $signed(quo_reg);
    assign qs_mag_full = qneg_reg ? ((quo_reg + NUM_W'((1 << QS_SH) - 1)) >> QS_SH)
                                  : (quo_reg >> QS_SH);

    // Multiplier operand magnitudes.
    logic [NUM_W-1:0] q_mag;
    logic [15:0]      p9_mag, p8_mag;
    assign q_mag  = q_reg[NUM_W-1] ? $unsigned(-q_reg) : $unsigned(q_reg);
    assign p9_mag = coef.p9[15] ? $unsigned(-coef.p9) : $unsigned(coef.p9);
    assign p8_mag = coef.p8[15] ? $unsigned(-coef.p8) : $unsigned(coef.p8);

    // Shared shift-add multiplier and signed products.
    logic [MA_W-1:0]        acc_sum;
    logic signed [MA_W-1:0] prod9, prod8, ta_full, tb_full;
    assign acc_sum = acc_reg + ma_reg;
    assign prod9   = coef.p9[15] ? -$signed(acc_reg) : $signed(acc_reg);
    assign prod8   = (q_reg[NUM_W-1] ^ coef.p8[15]) ? -$signed(acc_reg) : $signed(acc_reg);
    assign ta_full = prod9 >>> 25;
    assign tb_full = prod8 >>> 19;

    // Final sums and saturation.
    logic signed [SUM_W-1:0] sum, s1, sfin;
    logic [PRESS_W-1:0]      press_sat;
    assign sum  = SUM_W'(q_reg) + ta_reg + tb_reg;
    assign s1   = (sum >>> 8) + (SUM_W'(coef.p7) <<< 4);
    assign sfin = s1_reg >>> 8;
    assign press_sat = sfin[SUM_W-1] ? '0 :
                       (sfin > SUM_W'(PRESS_MAX)) ? PRESS_MAX : sfin[PRESS_W-1:0];

    logic out_free;
    assign out_free = !out_valid_reg || !out_stall;
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        temp_next      = temp_reg;
        fine_next      = fine_reg;
        dz_next        = dz_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        qneg_next      = qneg_reg;
        cnt_next       = cnt_reg;
        q_next         = q_reg;
        ma_next        = ma_reg;
        mb_next        = mb_reg;
        acc_next       = acc_reg;
        ta_next        = ta_reg;
        tb_next        = tb_reg;
        s1_next        = s1_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_temp_next  = out_temp_reg;
        out_fine_next  = out_fine_reg;
        out_press_next = out_press_reg;
        out_dz_next    = out_dz_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    temp_next = q_data.temp;
                    fine_next = q_data.fine;
                    den_next  = div_mag;
                    quo_next  = num_mag;
                    rem_next  = '0;
                    cnt_next  = '0;
                    qneg_next = q_data.num[NUM_W-1] ^ q_data.div[DIV_W-1];
                    if (q_data.div == '0)
                    begin
                        dz_next    = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        dz_next    = 1'b0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next = r2_ge ? r2_sub[DIV_W-1:0] : r2[DIV_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], r2_ge};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    state_next = ST_QS;
                end
            end
            ST_QS:
            begin
                q_next     = q_signed;
                ma_next    = MA_W'(qs_mag_full[QS_W-1:0]);
                mb_next    = qs_mag_full[QS_W-1:0];
                acc_next   = '0;
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                if (mb_reg != '0)
                begin
                    acc_next = mb_reg[0] ? acc_sum : acc_reg;
                    ma_next  = ma_reg << 1;
                    mb_next  = mb_reg >> 1;
                end
                else
                begin
                    ma_next    = acc_reg;
                    mb_next    = MB_W'(p9_mag);
                    acc_next   = '0;
                    state_next = ST_P9;
                end
            end
            ST_P9:
            begin
                if (mb_reg != '0)
                begin
                    acc_next = mb_reg[0] ? acc_sum : acc_reg;
                    ma_next  = ma_reg << 1;
                    mb_next  = mb_reg >> 1;
                end
                else
                begin
                    ta_next    = SUM_W'(ta_full);
                    ma_next    = MA_W'(q_mag);
                    mb_next    = MB_W'(p8_mag);
                    acc_next   = '0;
                    state_next = ST_P8;
                end
            end
            ST_P8:
            begin
                if (mb_reg != '0)
                begin
                    acc_next = mb_reg[0] ? acc_sum : acc_reg;
                    ma_next  = ma_reg << 1;
                    mb_next  = mb_reg >> 1;
                end
                else
                begin
                    tb_next    = SUM_W'(tb_full);
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                s1_next    = s1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_temp_next  = temp_reg;
                    out_fine_next  = fine_reg;
                    out_press_next = dz_reg ? '0 : press_sat;
                    out_dz_next    = dz_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            temp_reg      <= temp_next;
            fine_reg      <= fine_next;
            dz_reg        <= dz_next;
            den_reg       <= den_next;
            rem_reg       <= rem_next;
            quo_reg       <= quo_next;
            qneg_reg      <= qneg_next;
            cnt_reg       <= cnt_next;
            q_reg         <= q_next;
            ma_reg        <= ma_next;
            mb_reg        <= mb_next;
            acc_reg       <= acc_next;
            ta_reg        <= ta_next;
            tb_reg        <= tb_next;
            s1_reg        <= s1_next;
            out_temp_reg  <= out_temp_next;
            out_fine_reg  <= out_fine_next;
            out_press_reg <= out_press_next;
            out_dz_reg    <= out_dz_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign temperature    = out_temp_reg;
    assign fine_temp      = $signed(out_fine_reg);
    assign pressure       = out_press_reg;
    assign divide_by_zero = out_dz_reg;

endmodule

[hw/rtl/pressure_temperature_compensation.sv]
// Top level of the pressure and temperature compensation block.
// Holds the coefficient registers; instantiates ptc_front, ptc_queue and
// ptc_back. Uses ptc_pkg.
//
//   Channel | Direction | Handshake               | Beat carries
//   input   | in        | in_valid / in_stall     | raw_temp, raw_press
//   output  | out       | out_valid / out_stall   | temperature, fine_temp,
//           |           |                         | pressure, divide_by_zero
//   config  | in        | cfg_wr_en               | cfg_index, cfg_data
//
// The front pipeline takes a beat every cycle while fewer than QUEUE_DEPTH
// items are in flight. The back takes one item at a time: setup, the
// 78-step divider, one shift-add step per significant bit of |q >> 13|,
// |P9| and |P8| on the shift-add multiplier, then sum and output; a zero
// divisor goes straight from setup to output.
// Reset clears the coefficient registers, the queue and all valid flags.
// A stalled output holds its beat while the front keeps accepting.
module pressure_temperature_compensation import ptc_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic        [RAW_W-1:0]   raw_temp,
    input  logic        [RAW_W-1:0]   raw_press,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [TEMP_W-1:0]  temperature,
    output logic signed [FINE_W-1:0]  fine_temp,
    output logic        [PRESS_W-1:0] pressure,
    output logic                      divide_by_zero,
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]          cfg_data
);

    logic [47:0]    temp_coeffs_reg;
    logic [63:0]    press_low_reg;
    logic [63:0]    press_high_reg;
    logic [15:0]    press_nine_reg;
    coef_t          coef;
    logic           q_push, q_pop, q_empty;
    entry_t         q_wr_data, q_rd_data;

    // Coefficient registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_coeffs_reg <= '0;
            press_low_reg   <= '0;
            press_high_reg  <= '0;
            press_nine_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TEMP_COEFFS: temp_coeffs_reg <= cfg_data[47:0];
                REG_PRESS_LOW:   press_low_reg   <= cfg_data;
                REG_PRESS_HIGH:  press_high_reg  <= cfg_data;
                REG_PRESS_NINE:  press_nine_reg  <= cfg_data[15:0];
                default:         press_nine_reg  <= press_nine_reg;
            endcase
        end
    end

    // Coefficient slices.
    always_comb
    begin
        coef.t1 = temp_coeffs_reg[15:0];
        coef.t2 = $signed(temp_coeffs_reg[31:16]);
        coef.t3 = $signed(temp_coeffs_reg[47:32]);
        coef.p1 = press_low_reg[15:0];
        coef.p2 = $signed(press_low_reg[31:16]);
        coef.p3 = $signed(press_low_reg[47:32]);
        coef.p4 = $signed(press_low_reg[63:48]);
        coef.p5 = $signed(press_high_reg[15:0]);
        coef.p6 = $signed(press_high_reg[31:16]);
        coef.p7 = $signed(press_high_reg[47:32]);
        coef.p8 = $signed(press_high_reg[63:48]);
        coef.p9 = $signed(press_nine_reg);
    end

    ptc_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .raw_temp  (raw_temp),
        .raw_press (raw_press),
        .coef      (coef),
        .q_push    (q_push),
        .q_data    (q_wr_data),
        .q_pop     (q_pop)
    );

    ptc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wr_data),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (q_rd_data)
    );

    ptc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .coef           (coef),
        .q_empty        (q_empty),
        .q_data         (q_rd_data),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .temperature    (temperature),
        .fine_temp      (fine_temp),
        .pressure       (pressure),
        .divide_by_zero (divide_by_zero)
    );

endmodule

[hw/rtl/ptc_checker.sv]
// Port-level checker for the compensation block, bound to the top level.
// Uses ptc_pkg for the port widths.
module ptc_checker import ptc_pkg::*; (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic        [RAW_W-1:0]   raw_temp,
    input logic        [RAW_W-1:0]   raw_press,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic signed [TEMP_W-1:0]  temperature,
    input logic signed [FINE_W-1:0]  fine_temp,
    input logic        [PRESS_W-1:0] pressure,
    input logic                      divide_by_zero,
    input logic                      cfg_wr_en,
    input logic [CFG_IDX_W-1:0]      cfg_index,
    input logic [CFG_W-1:0]          cfg_data
);

    // No result beat is offered while reset is held.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("out_valid high during reset");

    // A stalled result beat stays and holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pressure)
            && $stable(temperature) && $stable(fine_temp) && $stable(divide_by_zero))
        else $error("stalled output beat changed");

    // A zero divisor always reports zero pressure.
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_by_zero |-> pressure == '0)
        else $error("divide_by_zero with nonzero pressure");

endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (.*);

[sim/testbench.sv]
// Self-checking testbench for pressure_temperature_compensation.
// Drives raw conversion pairs under several coefficient sets and compares every
// output beat with a wide-integer predictor. Depends on ptc_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
    import ptc_pkg::*;

    typedef logic signed [191:0] wide_t;

    typedef struct {
        logic [RAW_W-1:0] rt;
        logic [RAW_W-1:0] rp;
    } raw_pair_t;

    typedef struct {
        logic [TEMP_W-1:0]  temp;
        logic [FINE_W-1:0]  fine;
        logic [PRESS_W-1:0] press;
        logic               dz;
    } comp_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic        [RAW_W-1:0]   raw_temp;
    logic        [RAW_W-1:0]   raw_press;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [TEMP_W-1:0]  temperature;
    logic signed [FINE_W-1:0]  fine_temp;
    logic        [PRESS_W-1:0] pressure;
    logic                      divide_by_zero;
    logic                      cfg_wr_en;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_W-1:0]          cfg_data;

    // Local copy of the coefficient registers.
    logic [47:0] cal_temp;
    logic [63:0] cal_plow;
    logic [63:0] cal_phigh;
    logic [15:0] cal_p9;

    raw_pair_t    pending_pairs[$];
    comp_result_t expected_results[$];
    int           errors;
    int           mismatches;
    int           pairs_sent;
    int           results_seen;
    int           dz_seen;
    int           sat_seen;
    int           idle_pct;

    pressure_temperature_compensation dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .raw_temp(raw_temp), .raw_press(raw_press),
        .out_valid(out_valid), .out_stall(out_stall),
        .temperature(temperature), .fine_temp(fine_temp),
        .pressure(pressure), .divide_by_zero(divide_by_zero),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Exact compensation of one raw pair with the current coefficients.
    function automatic comp_result_t compensate(logic [RAW_W-1:0] rtv,
                                                logic [RAW_W-1:0] rpv);
        comp_result_t r;
        wide_t rt, rp, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        wide_t a1, a2, dt, tf, tc, d, v1, v2, dw, n0, q, qs, ta, tb, s;
        logic signed [63:0] div64;
        rt = $signed({1'b0, rtv});
        rp = $signed({1'b0, rpv});
        t1 = $signed({1'b0, cal_temp[15:0]});
        t2 = $signed(cal_temp[31:16]);
        t3 = $signed(cal_temp[47:32]);
        p1 = $signed({1'b0, cal_plow[15:0]});
        p2 = $signed(cal_plow[31:16]);
        p3 = $signed(cal_plow[47:32]);
        p4 = $signed(cal_plow[63:48]);
        p5 = $signed(cal_phigh[15:0]);
        p6 = $signed(cal_phigh[31:16]);
        p7 = $signed(cal_phigh[47:32]);
        p8 = $signed(cal_phigh[63:48]);
        p9 = $signed(cal_p9);

        // Temperature path.
        a1 = (((rt >>> 3) - 2 * t1) * t2) >>> 11;
        dt = (rt >>> 4) - t1;
        a2 = (((dt * dt) >>> 12) * t3) >>> 14;
        tf = a1 + a2;
        tc = (tf * 5 + ROUND_BIAS) >>> 8;

        // Pressure divisor, truncated to a signed 64-bit value.
        d  = tf - TEMP_OFFSET;
        v2 = d * d * p6 + d * p5 * 131072 + (p4 <<< 35);
        v1 = ((d * d * p3) >>> 8) + d * p2 * 4096;
        dw = (((wide_t'(1) <<< 47) + v1) * p1) >>> 33;
        div64 = dw[63:0];

        r.temp = tc[TEMP_W-1:0];
        r.fine = tf[FINE_W-1:0];
        r.press = '0;
        r.dz = 1'b0;
        if (div64 == 0)
        begin
            r.dz = 1'b1;
        end
        else
        begin
            dw = div64;
            n0 = (PRESS_BASE - rp) * (wide_t'(1) <<< 31) - v2;
            q  = (n0 * SCALE) / dw;
            qs = q >>> 13;
            ta = (p9 * qs * qs) >>> 25;
            tb = (p8 * q) >>> 19;
            s  = (((q + ta + tb) >>> 8) + p7 * 16) >>> 8;
            if (s < 0)
                r.press = '0;
            else if (s > PRESS_MAX)
                r.press = PRESS_MAX;
            else
                r.press = s[PRESS_W-1:0];
        end
        return r;
    endfunction

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Input driver: one beat per accepted pair, random idle cycles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            raw_temp  <= '0;
            raw_press <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(compensate(raw_temp, raw_press));
                pairs_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_pairs.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    raw_temp  <= pending_pairs[0].rt;
                    raw_press <= pending_pairs[0].rp;
                    void'(pending_pairs.pop_front());
                    in_valid  <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: random stall, compare each beat with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    if (mismatches < 10)
                        $display("ERROR: unexpected output beat, temp %0d press %0d",
                                 temperature, pressure);
                    mismatches++;
                end
                else
                begin
                    comp_result_t e;
                    e = expected_results.pop_front();
                    if (e.dz)
                        dz_seen++;
                    if (e.press == PRESS_MAX)
                        sat_seen++;
                    if (temperature !== e.temp || fine_temp !== e.fine ||
                        pressure !== e.press || divide_by_zero !== e.dz)
                    begin
                        errors++;
                        if (mismatches < 10)
                            $display("ERROR: beat %0d exp t=%h f=%h p=%h dz=%b got t=%h f=%h p=%h dz=%b",
                                     results_seen, e.temp, e.fine, e.press, e.dz,
                                     temperature, fine_temp, pressure, divide_by_zero);
                        mismatches++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    // Write one coefficient register and update the local copy.
    task automatic write_reg(cfg_reg_t idx, logic [63:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_TEMP_COEFFS: cal_temp  = value[47:0];
            REG_PRESS_LOW:   cal_plow  = value;
            REG_PRESS_HIGH:  cal_phigh = value;
            REG_PRESS_NINE:  cal_p9    = value[15:0];
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_all(logic [63:0] t, logic [63:0] pl, logic [63:0] ph,
                            logic [63:0] p9);
        write_reg(REG_TEMP_COEFFS, t);
        write_reg(REG_PRESS_LOW, pl);
        write_reg(REG_PRESS_HIGH, ph);
        write_reg(REG_PRESS_NINE, p9);
    endtask

    task automatic add_pair(logic [RAW_W-1:0] rt, logic [RAW_W-1:0] rp);
        raw_pair_t p;
        p.rt = rt;
        p.rp = rp;
        pending_pairs.push_back(p);
    endtask

    // Queue random pairs, mostly near realistic readings, some anywhere.
    task automatic add_random(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(3) == 0)
                add_pair(RAW_W'($urandom), RAW_W'($urandom));
            else
                add_pair(RAW_W'($urandom_range(560000, 480000)),
                         RAW_W'($urandom_range(480000, 250000)));
        end
    endtask

    // Let every queued pair drain, then a margin for the back end.
    task automatic drain();
        while (pending_pairs.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Stimulus sequence.
    initial
    begin
        // Reset falls after time zero so every reset process sees the edge.
        rst_n     = 1'b1;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        cal_temp  = '0;
        cal_plow  = '0;
        cal_phigh = '0;
        cal_p9    = '0;
        errors = 0; mismatches = 0; pairs_sent = 0; results_seen = 0;
        dz_seen = 0; sat_seen = 0;
        idle_pct = 22;
        #1;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset coefficients: P1 is zero, so every divisor is zero.
        add_pair('0, '0);
        add_pair('1, '1);
        drain();

        // Typical calibration, high garbage bits on the narrow registers.
        load_all({16'hDEAD, 16'shFC18, 16'd26435, 16'd27504},
                 {16'd2855, 16'd3024, 16'hD043, 16'd36477},
                 {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
                 {48'hFFFF_1234_5678, 16'd6000});
        add_pair(20'd519888, 20'd415148);
        add_pair('0, '0);
        add_pair('1, '1);
        add_pair('0, '1);
        add_pair('1, '0);
        add_pair(20'h80000, 20'h80000);
        add_pair(20'h55555, 20'hAAAAA);
        add_pair(20'hAAAAA, 20'h55555);
        add_pair(20'd519888, 20'd1);
        add_pair(20'd519888, 20'hFFFFE);
        drain();

        // Extremes: all ones, maximum positive, minimum negative slices.
        load_all('1, '1, '1, '1);
        add_pair(20'd519888, 20'd415148);
        add_pair('1, '0);
        add_pair('0, '1);
        drain();
        load_all(64'h7FFF_7FFF_FFFF, 64'h7FFF_7FFF_7FFF_FFFF,
                 64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF);
        add_pair('0, '0);
        add_pair('1, '1);
        drain();
        load_all(64'h8000_8000_0000, 64'h8000_8000_8000_0001,
                 64'h8000_8000_8000_8000, 64'h8000);
        add_pair('0, '0);
        add_pair('1, '1);
        drain();

        // Long runs with typical coefficients, first with no idling on either side, then with random idling.
        load_all({16'shFC18, 16'd26435, 16'd27504},
                 {16'd2855, 16'd3024, 16'hD043, 16'd36477},
                 {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000);
        idle_pct = 0;
        add_random(300);
        drain();
        idle_pct = 22;
        add_random(300);
        drain();

        // Random coefficient sets, some with P1 cleared for a zero divisor.
        for (int ph = 0; ph < 9; ph++)
        begin
            logic [63:0] pl;
            pl = rand64();
            if (ph % 4 == 3)
                pl[15:0] = '0;
            load_all(rand64(), pl, rand64(), rand64());
            add_random(105);
            drain();
        end

        $display("Covered %0d pairs over 15 coefficient sets with random idling.",
                 pairs_sent);
        $display("Zero-divisor results: %0d, saturated pressures: %0d, mismatches: %0d.",
                 dz_seen, sat_seen, mismatches);
        if (errors == 0 && expected_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #20_000_000;
        $display("TIMEOUT: run did not finish");
        $display("DONE: errors detected");
        $finish;
    end

endmodule
